@@ rtl/core/cara_pkg.sv @@
// shared types, constants and station-entry definitions for the rate adapter
package cara_pkg;

  localparam int unsigned STATIONS = 64;
  localparam int unsigned ST_W     = $clog2(STATIONS);
  localparam int unsigned MAX_RATES = 16;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned NSUP_W  = 5;
  localparam int unsigned RATE_W  = 4;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CNT_W-1:0]  CNT_MAX = '1;
  localparam logic [NSUP_W-1:0] CAP_MAX = NSUP_W'(MAX_RATES);
  localparam logic [NSUP_W-1:0] CAP_MIN = NSUP_W'(1);

  typedef enum logic [OP_W-1:0] {
    OP_DATA_OK   = 2'd0,
    OP_DATA_FAIL = 2'd1,
    OP_QUERY     = 2'd2,
    OP_RSVD      = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROBE_THR   = 8'd0,
    CFG_FAILURE_THR = 8'd1,
    CFG_SUCCESS_THR = 8'd2,
    CFG_TIMER_TMO   = 8'd3
  } cfg_idx_e;

  localparam logic [CNT_W-1:0] PROBE_THR_RST   = 8'd1;
  localparam logic [CNT_W-1:0] FAILURE_THR_RST = 8'd2;
  localparam logic [CNT_W-1:0] SUCCESS_THR_RST = 8'd10;
  localparam logic [CNT_W-1:0] TIMER_TMO_RST   = 8'd15;

  typedef struct packed {
    logic [CNT_W-1:0] probe_thr;
    logic [CNT_W-1:0] failure_thr;
    logic [CNT_W-1:0] success_thr;
    logic [CNT_W-1:0] timer_tmo;
  } cfg_t;

  typedef struct packed {
    logic [RATE_W-1:0] rate;
    logic [CNT_W-1:0]  success;
    logic [CNT_W-1:0]  failure;
    logic [CNT_W-1:0]  tick;
  } entry_t;

  typedef struct packed {
    logic [RATE_W-1:0] rate_index;
    logic              use_rts;
    logic              rate_changed;
  } result_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? CNT_MAX : v + CNT_W'(1);
  endfunction

endpackage

@@ rtl/core/cara_if.sv @@
// handshake interfaces for event input, result output and register writes
interface cara_in_if;
  logic                          valid;
  logic                          ready;
  logic [cara_pkg::OP_W-1:0]     operation;
  logic [cara_pkg::ST_W-1:0]     station;
  logic [cara_pkg::NSUP_W-1:0]   n_supported;
  logic                          rts_normally;

  modport source (output valid, operation, station, n_supported, rts_normally, input ready);
  modport sink   (input valid, operation, station, n_supported, rts_normally, output ready);
endinterface

interface cara_out_if;
  logic                          valid;
  logic                          ready;
  logic [cara_pkg::RATE_W-1:0]   rate_index;
  logic                          use_rts;
  logic                          rate_changed;

  modport source (output valid, rate_index, use_rts, rate_changed, input ready);
  modport sink   (input valid, rate_index, use_rts, rate_changed, output ready);
endinterface

interface cara_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [cara_pkg::CFG_IDX_W-1:0]   index;
  logic [cara_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/cara_cfg.sv @@
// threshold register file written through the configuration channel
module cara_cfg (
  input  logic            clk_i,
  input  logic            rst_ni,
  cara_cfg_if.sink        cfg_i,
  output cara_pkg::cfg_t  cfg_o
);

  cara_pkg::cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.probe_thr   <= cara_pkg::PROBE_THR_RST;
      cfg_q.failure_thr <= cara_pkg::FAILURE_THR_RST;
      cfg_q.success_thr <= cara_pkg::SUCCESS_THR_RST;
      cfg_q.timer_tmo   <= cara_pkg::TIMER_TMO_RST;
    end else if (cfg_i.valid) begin
      unique case (cara_pkg::cfg_idx_e'(cfg_i.index))
        cara_pkg::CFG_PROBE_THR:   cfg_q.probe_thr   <= cfg_i.data;
        cara_pkg::CFG_FAILURE_THR: cfg_q.failure_thr <= cfg_i.data;
        cara_pkg::CFG_SUCCESS_THR: cfg_q.success_thr <= cfg_i.data;
        cara_pkg::CFG_TIMER_TMO:   cfg_q.timer_tmo   <= cfg_i.data;
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/core/cara_stat_mem.sv @@
// per-station state memory with registered read and per-entry valid bits
module cara_stat_mem (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rd_en_i,
  input  logic [cara_pkg::ST_W-1:0]   rd_addr_i,
  output cara_pkg::entry_t            rd_data_o,
  input  logic                        wr_en_i,
  input  logic [cara_pkg::ST_W-1:0]   wr_addr_i,
  input  cara_pkg::entry_t            wr_data_i
);

  cara_pkg::entry_t               mem [cara_pkg::STATIONS];
  cara_pkg::entry_t               rd_data_q;
  logic [cara_pkg::STATIONS-1:0]  valid_q;
  logic                           rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= valid_q[rd_addr_i];
      end
    end
  end

  // never-written entries read as cleared
  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

@@ rtl/core/cara_update.sv @@
// counter and rate update for one event, plus rts decision
module cara_update (
  input  cara_pkg::cfg_t                cfg_i,
  input  logic [cara_pkg::OP_W-1:0]     op_i,
  input  logic [cara_pkg::NSUP_W-1:0]   nsup_i,
  input  logic                          rts_normally_i,
  input  cara_pkg::entry_t              entry_i,
  output cara_pkg::entry_t              entry_o,
  output cara_pkg::result_t             result_o
);

  logic [cara_pkg::NSUP_W-1:0] cap;
  logic [cara_pkg::NSUP_W-1:0] rate_inc;
  logic [cara_pkg::CNT_W-1:0]  tick_inc;
  logic [cara_pkg::CNT_W-1:0]  succ_inc;
  logic [cara_pkg::CNT_W-1:0]  fail_inc;
  cara_pkg::entry_t            nxt;

  always_comb begin
    if (nsup_i > cara_pkg::CAP_MAX) begin
      cap = cara_pkg::CAP_MAX;
    end else if (nsup_i == '0) begin
      cap = cara_pkg::CAP_MIN;
    end else begin
      cap = nsup_i;
    end
  end

  assign rate_inc = {1'b0, entry_i.rate} + cara_pkg::NSUP_W'(1);
  assign tick_inc = cara_pkg::sat_inc(entry_i.tick);
  assign succ_inc = cara_pkg::sat_inc(entry_i.success);
  assign fail_inc = cara_pkg::sat_inc(entry_i.failure);

  always_comb begin
    nxt = entry_i;
    unique case (cara_pkg::op_e'(op_i))
      cara_pkg::OP_DATA_OK: begin
        nxt.tick    = tick_inc;
        nxt.success = succ_inc;
        nxt.failure = '0;
        if (succ_inc == cfg_i.success_thr || tick_inc >= cfg_i.timer_tmo) begin
          if (rate_inc < cap) begin
            nxt.rate = rate_inc[cara_pkg::RATE_W-1:0];
          end
          nxt.tick    = '0;
          nxt.success = '0;
        end
      end
      cara_pkg::OP_DATA_FAIL: begin
        nxt.tick    = tick_inc;
        nxt.failure = fail_inc;
        nxt.success = '0;
        if (fail_inc >= cfg_i.failure_thr) begin
          if (entry_i.rate != '0) begin
            nxt.rate = entry_i.rate - cara_pkg::RATE_W'(1);
          end
          nxt.failure = '0;
          nxt.tick    = '0;
        end
      end
      cara_pkg::OP_QUERY: ;
      cara_pkg::OP_RSVD:  ;
    endcase
  end

  assign entry_o               = nxt;
  assign result_o.rate_index   = nxt.rate;
  assign result_o.use_rts      = rts_normally_i || (nxt.failure >= cfg_i.probe_thr);
  assign result_o.rate_changed = (nxt.rate != entry_i.rate);

endmodule

@@ rtl/core/collision_aware_rate_adapter.sv @@
// top level of the per-station collision-aware transmit rate adapter
//
// in_i carries one event word: operation (data ok, data failed, query), the
// station index, the station's supported-rate count and the rts hint.
// out_o returns one result word per event: the station's rate index after
// the event, whether rts protection is needed and whether the rate moved.
// cfg_i writes the four 8-bit thresholds by index; write only while idle.
// throughput: one event per cycle while out_o is ready. the station
// state memory is read at accept and written back as the update stage
// advances, with a bypass from the last write so back-to-back events
// to the same station see fresh state.
// reset: all station entries read as zero (per-entry valid bits clear at
// once, no clearing pass) and thresholds return to 1, 2, 10 and 15.
// a stalled receiver holds the result word; the update stage then holds
// its word and in_i.ready drops until out_o drains.
module collision_aware_rate_adapter (
  input  logic         clk_i,
  input  logic         rst_ni,
  cara_in_if.sink      in_i,
  cara_out_if.source   out_o,
  cara_cfg_if.sink     cfg_i
);

  cara_pkg::cfg_t                 cfg;
  cara_pkg::entry_t               rd_entry;
  cara_pkg::entry_t               cur_entry;
  cara_pkg::entry_t               nxt_entry;
  cara_pkg::result_t              result;

  logic                           s1_valid_q;
  logic [cara_pkg::OP_W-1:0]      s1_op_q;
  logic [cara_pkg::ST_W-1:0]      s1_st_q;
  logic [cara_pkg::NSUP_W-1:0]    s1_nsup_q;
  logic                           s1_norm_q;

  logic                           wb_valid_q;
  logic [cara_pkg::ST_W-1:0]      wb_st_q;
  cara_pkg::entry_t               wb_entry_q;

  logic                           out_valid_q;
  cara_pkg::result_t              out_res_q;

  logic                           in_fire;
  logic                           s1_adv;
  logic                           s1_fire;

  assign s1_adv   = !out_valid_q || out_o.ready;
  assign s1_fire  = s1_valid_q && s1_adv;
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_fire  = in_i.valid && in_i.ready;

  cara_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  cara_stat_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_fire),
    .rd_addr_i (in_i.station),
    .rd_data_o (rd_entry),
    .wr_en_i   (s1_fire),
    .wr_addr_i (s1_st_q),
    .wr_data_i (nxt_entry)
  );

  // bypass the word written at the same edge as this read
  assign cur_entry = (wb_valid_q && wb_st_q == s1_st_q) ? wb_entry_q : rd_entry;

  cara_update u_update (
    .cfg_i          (cfg),
    .op_i           (s1_op_q),
    .nsup_i         (s1_nsup_q),
    .rts_normally_i (s1_norm_q),
    .entry_i        (cur_entry),
    .entry_o        (nxt_entry),
    .result_o       (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      wb_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (s1_fire) begin
        wb_valid_q <= 1'b1;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q   <= in_i.operation;
      s1_st_q   <= in_i.station;
      s1_nsup_q <= in_i.n_supported;
      s1_norm_q <= in_i.rts_normally;
    end
    if (s1_fire) begin
      wb_st_q    <= s1_st_q;
      wb_entry_q <= nxt_entry;
      out_res_q  <= result;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.rate_index   = out_res_q.rate_index;
  assign out_o.use_rts      = out_res_q.use_rts;
  assign out_o.rate_changed = out_res_q.rate_changed;

endmodule

@@ verif/cara_rate_checker.sv @@
// checker for the rate adapter: predicts each result word and compares it with the block
`timescale 1ns / 1ps

module cara_rate_checker
  import cara_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  cara_in_if          in_i,
  cara_out_if         out_i,
  cara_cfg_if         cfg_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  cfg_t              thr;
  logic [RATE_W-1:0] rate_tbl    [STATIONS];
  logic [CNT_W-1:0]  success_tbl [STATIONS];
  logic [CNT_W-1:0]  failure_tbl [STATIONS];
  logic [CNT_W-1:0]  tick_tbl    [STATIONS];
  result_t           expected_results [$];
  result_t           got;
  result_t           want;
  int unsigned       errors;

  function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + CNT_W'(1);
  endfunction

  function automatic result_t predict_station_event(input op_e op,
                                                    input logic [ST_W-1:0] st,
                                                    input logic [NSUP_W-1:0] nsup,
                                                    input logic rts);
    logic [NSUP_W-1:0] cap;
    logic [RATE_W-1:0] old_rate;
    result_t           res;
    cap = (nsup > CAP_MAX) ? CAP_MAX : nsup;
    if (cap == '0) cap = NSUP_W'(1);
    old_rate = rate_tbl[st];
    case (op)
      OP_DATA_OK: begin
        tick_tbl[st]    = count_up(tick_tbl[st]);
        success_tbl[st] = count_up(success_tbl[st]);
        failure_tbl[st] = '0;
        if (success_tbl[st] == thr.success_thr || tick_tbl[st] >= thr.timer_tmo) begin
          if (NSUP_W'(rate_tbl[st]) + NSUP_W'(1) < cap) rate_tbl[st] = rate_tbl[st] + 1'b1;
          tick_tbl[st]    = '0;
          success_tbl[st] = '0;
        end
      end
      OP_DATA_FAIL: begin
        tick_tbl[st]    = count_up(tick_tbl[st]);
        failure_tbl[st] = count_up(failure_tbl[st]);
        success_tbl[st] = '0;
        if (failure_tbl[st] >= thr.failure_thr) begin
          if (rate_tbl[st] != '0) rate_tbl[st] = rate_tbl[st] - 1'b1;
          failure_tbl[st] = '0;
          tick_tbl[st]    = '0;
        end
      end
      default: ;
    endcase
    res.rate_index   = rate_tbl[st];
    res.use_rts      = rts || (failure_tbl[st] >= thr.probe_thr);
    res.rate_changed = (rate_tbl[st] != old_rate);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr.probe_thr   = PROBE_THR_RST;
      thr.failure_thr = FAILURE_THR_RST;
      thr.success_thr = SUCCESS_THR_RST;
      thr.timer_tmo   = TIMER_TMO_RST;
      for (int s = 0; s < STATIONS; s++) begin
        rate_tbl[s]    = '0;
        success_tbl[s] = '0;
        failure_tbl[s] = '0;
        tick_tbl[s]    = '0;
      end
      expected_results.delete();
      errors = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_i.valid && out_i.ready) begin
        got.rate_index   = out_i.rate_index;
        got.use_rts      = out_i.use_rts;
        got.rate_changed = out_i.rate_changed;
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: unexpected word rate %0d rts %0b changed %0b",
                     got.rate_index, got.use_rts, got.rate_changed);
        end else begin
          want = expected_results.pop_front();
          if (got.rate_index !== want.rate_index || got.use_rts !== want.use_rts ||
              got.rate_changed !== want.rate_changed) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected rate %0d rts %0b changed %0b, got %0d %0b %0b",
                       want.rate_index, want.use_rts, want.rate_changed,
                       got.rate_index, got.use_rts, got.rate_changed);
          end
        end
      end
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_idx_e'(cfg_i.index))
          CFG_PROBE_THR:   thr.probe_thr   = cfg_i.data;
          CFG_FAILURE_THR: thr.failure_thr = cfg_i.data;
          CFG_SUCCESS_THR: thr.success_thr = cfg_i.data;
          CFG_TIMER_TMO:   thr.timer_tmo   = cfg_i.data;
          default: ;
        endcase
      end
      if (in_i.valid && in_i.ready)
        expected_results.push_back(predict_station_event(op_e'(in_i.operation), in_i.station,
                                                         in_i.n_supported, in_i.rts_normally));
      fail_count_o <= errors;
      pending_o    <= expected_results.size();
    end
  end

endmodule

@@ verif/tb_collision_aware_rate_adapter.sv @@
// testbench top for the rate adapter: clock, reset, event and threshold stimulus, verdict
`timescale 1ns / 1ps

module tb_collision_aware_rate_adapter;
  import cara_pkg::*;

  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned LIMIT       = 200000;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycles;
  bit          tx_no_idle;
  bit          rx_no_idle;
  bit          rx_hold_req;

  logic [NSUP_W-1:0] nsup_of [STATIONS];

  cara_in_if  in_bus ();
  cara_out_if out_bus ();
  cara_cfg_if cfg_bus ();

  collision_aware_rate_adapter i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .cfg_i  (cfg_bus)
  );

  cara_rate_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_bus),
    .out_i        (out_bus),
    .cfg_i        (cfg_bus),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_event(input op_e op, input logic [ST_W-1:0] st,
                            input logic [NSUP_W-1:0] nsup, input logic rts);
    if (!tx_no_idle && $urandom_range(0, 99) < 24) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_bus.valid        <= 1'b1;
    in_bus.operation    <= op;
    in_bus.station      <= st;
    in_bus.n_supported  <= nsup;
    in_bus.rts_normally <= rts;
    do @(posedge clk_i); while (!in_bus.ready);
  endtask

  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic set_thresholds(input logic [CNT_W-1:0] probe, input logic [CNT_W-1:0] fail,
                                input logic [CNT_W-1:0] succ, input logic [CNT_W-1:0] tmo);
    cfg_idx_e idx [4];
    logic [CNT_W-1:0] val [4];
    idx = '{CFG_PROBE_THR, CFG_FAILURE_THR, CFG_SUCCESS_THR, CFG_TIMER_TMO};
    val = '{probe, fail, succ, tmo};
    for (int k = 0; k < 4; k++) begin
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= idx[k];
      cfg_bus.data  <= val[k];
      do @(posedge clk_i); while (!cfg_bus.ready);
    end
    cfg_bus.valid <= 1'b0;
  endtask

  initial begin : result_sink
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        out_bus.ready <= rx_no_idle || ($urandom_range(0, 99) >= 24);
      end
    end
  end

  initial begin : stimulus
    op_e               op;
    op_e               burst_op;
    logic [ST_W-1:0]   st;
    logic [ST_W-1:0]   burst_st;
    logic [ST_W-1:0]   pool [4];
    logic [NSUP_W-1:0] nsup;
    logic              rts;
    int                burst_left;
    int                n_items;
    int                r;
    cycles      = 0;
    tx_no_idle  = 1'b0;
    rx_no_idle  = 1'b0;
    rx_hold_req = 1'b0;
    burst_left  = 0;
    rst_ni = 1'b0;
    in_bus.valid        <= 1'b0;
    in_bus.operation    <= OP_QUERY;
    in_bus.station      <= '0;
    in_bus.n_supported  <= '0;
    in_bus.rts_normally <= 1'b0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= CFG_PROBE_THR;
    cfg_bus.data  <= '0;
    for (int s = 0; s < STATIONS; s++) nsup_of[s] = NSUP_W'($urandom_range(1, 16));
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset thresholds, unused code, rate floor
    send_event(OP_QUERY, 0, 0, 1'b0);
    send_event(OP_RSVD, 63, 31, 1'b1);
    send_event(OP_DATA_FAIL, 0, 16, 1'b0);
    send_event(OP_DATA_FAIL, 0, 16, 1'b0);
    send_event(OP_DATA_OK, 0, 16, 1'b1);
    // every success raises, cap of zero, rate above cap
    wait_drained();
    set_thresholds(1, 2, 10, 0);
    send_event(OP_DATA_OK, 5, 0, 1'b0);
    repeat (3) send_event(OP_DATA_OK, 5, 31, 1'b0);
    repeat (2) send_event(OP_DATA_OK, 6, 2, 1'b0);
    send_event(OP_DATA_OK, 5, 2, 1'b0);
    repeat (2) send_event(OP_DATA_FAIL, 5, 2, 1'b0);
    // every failure lowers, rts always on
    wait_drained();
    set_thresholds(0, 0, 10, 15);
    send_event(OP_DATA_FAIL, 5, 2, 1'b0);
    send_event(OP_QUERY, 7, 16, 1'b0);
    send_event(OP_DATA_FAIL, 0, 16, 1'b0);
    wait_drained();
    set_thresholds(255, 255, 255, 255);
    send_event(OP_DATA_OK, 42, 21, 1'b0);
    send_event(OP_DATA_FAIL, 21, 10, 1'b1);

    for (int ph = 0; ph < 8; ph++) begin
      wait_drained();
      case (ph)
        0: set_thresholds(0, 0, 0, 0);
        1: set_thresholds(255, 255, 255, 255);
        2: set_thresholds(CNT_W'($urandom_range(0, 3)), 255, 0, 255);
        default: set_thresholds(CNT_W'($urandom_range(0, 4)), CNT_W'($urandom_range(0, 5)),
                                CNT_W'($urandom_range(0, 16)),
                                ($urandom_range(0, 99) < 25) ? CNT_W'($urandom_range(0, 255))
                                                             : CNT_W'($urandom_range(0, 30)));
      endcase
      for (int k = 0; k < 4; k++) pool[k] = ST_W'($urandom_range(0, STATIONS - 1));
      tx_no_idle = (ph == 4);
      rx_no_idle = (ph == 4);
      burst_left = 0;
      n_items    = (ph == 2) ? 320 : 195;
      for (int i = 0; i < n_items; i++) begin
        if ((ph == 3 || ph == 6) && i == 80) rx_hold_req = 1'b1;
        if (ph == 5 && i == 100) wait_drained();
        rts = 1'($urandom_range(0, 1));
        if (ph == 2) begin
          // long failure runs on one station push its timer into saturation
          if ($urandom_range(0, 99) < 95) begin
            st = pool[0];
            op = (i % 50 == 49) ? OP_DATA_OK : OP_DATA_FAIL;
            nsup = nsup_of[st];
          end else begin
            op   = op_e'($urandom_range(0, 3));
            st   = ST_W'($urandom_range(0, STATIONS - 1));
            nsup = NSUP_W'($urandom_range(0, 31));
          end
        end else begin
          if (burst_left == 0 && $urandom_range(0, 99) < 65) begin
            burst_left = $urandom_range(2, 24);
            burst_op   = ($urandom_range(0, 99) < 60) ? OP_DATA_OK : OP_DATA_FAIL;
            burst_st   = pool[$urandom_range(0, 3)];
          end
          if (burst_left != 0) begin
            burst_left--;
            st = burst_st;
            op = burst_op;
            r  = $urandom_range(0, 99);
            if (r < 8) op = (burst_op == OP_DATA_OK) ? OP_DATA_FAIL : OP_DATA_OK;
            else if (r < 12) op = OP_QUERY;
            nsup = ($urandom_range(0, 99) < 90) ? nsup_of[st] : NSUP_W'($urandom_range(0, 31));
          end else begin
            op   = op_e'($urandom_range(0, 3));
            st   = ST_W'($urandom_range(0, STATIONS - 1));
            nsup = NSUP_W'($urandom_range(0, 31));
          end
        end
        send_event(op, st, nsup, rts);
      end
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/cara_pkg.sv
rtl/core/cara_if.sv
rtl/core/cara_cfg.sv
rtl/core/cara_stat_mem.sv
rtl/core/cara_update.sv
rtl/core/collision_aware_rate_adapter.sv
verif/cara_rate_checker.sv
verif/tb_collision_aware_rate_adapter.sv
